### hw/rtl/pvu_pkg.sv
// ----------------------------------------------------------------------------
// pvu_pkg
// shared types, constants and tables for the polar vector unit
// ----------------------------------------------------------------------------
package pvu_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int AngleBitsDefault   = 16;
   localparam int TableLen           = 30;

   localparam logic [2:0] CMD_TO_POLAR = 3'd0;
   localparam logic [2:0] CMD_TO_POINT = 3'd1;
   localparam logic [2:0] CMD_ADD      = 3'd2;
   localparam logic [2:0] CMD_SCALE    = 3'd3;
   localparam logic [2:0] CMD_ROTATE   = 3'd4;

   localparam logic [31:0] GAIN_INV     = 32'd2608131496;
   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   // working width for the rotation datapath
   localparam int WW = 40;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] mag_a;
      logic [15:0]        ang_a;
      logic signed [31:0] mag_b;
      logic [15:0]        ang_b;
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [31:0] factor;
   } req_type;

   typedef struct packed {
      logic signed [31:0] x_out;
      logic signed [31:0] y_out;
      logic signed [31:0] mag_out;
      logic [15:0]        ang_out;
      logic               saturated;
   } rsp_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

endpackage

### hw/rtl/pvu_fifo.sv
// ----------------------------------------------------------------------------
// pvu_fifo
// small register queue with combinational head read, used between stages
// ----------------------------------------------------------------------------
module pvu_fifo #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             empty
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   logic [Width-1:0] mem_ff [Depth];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == (AW+1)'(Depth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

### hw/rtl/pvu_front.sv
// ----------------------------------------------------------------------------
// pvu_front
// classifies a request, aligns angles and prepares rotation operands
// ----------------------------------------------------------------------------
module pvu_front #(
   parameter int AngleBits = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  pvu_pkg::req_type    in_data,
   input  logic                in_valid,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [2:0]          out_cmd,
   output logic signed [pvu_pkg::WW-1:0] out_xa,
   output logic signed [pvu_pkg::WW-1:0] out_xb,
   output logic [31:0]         out_za,
   output logic [31:0]         out_zb,
   output logic signed [31:0]  out_px,
   output logic signed [31:0]  out_py,
   output logic signed [31:0]  out_mag,
   output logic signed [31:0]  out_factor,
   output logic [15:0]         out_ang
);
   import pvu_pkg::*;

   localparam int Sh = 32 - AngleBits;
   localparam logic [31:0] AMask = (AngleBits >= 32) ? 32'hFFFF_FFFF
                                  : ((32'd1 << AngleBits) - 32'd1);

   // stage 1: gain multiply, stage 2: output register
   logic        v1_ff, v2_ff;
   req_type     r1_ff;
   logic [63:0] pa_ff, pb_ff;
   logic        na_ff, nb_ff;
   logic        adv;
   logic [31:0] ma_abs, mb_abs;
   logic [31:0] wa, wb, ang_sum;

   assign adv      = !v2_ff || out_ready;
   assign in_ready = adv || !v1_ff;
   assign out_valid = v2_ff;

   assign ma_abs = in_data.mag_a[31] ? 32'(-in_data.mag_a) : 32'(in_data.mag_a);
   assign mb_abs = in_data.mag_b[31] ? 32'(-in_data.mag_b) : 32'(in_data.mag_b);

   function automatic logic signed [WW-1:0] gain_out(input logic [63:0] p,
                                                      input logic neg);
      logic [63:0] r;
      begin
         r = (p + 64'h8000_0000) >> 32;
         return neg ? -(WW'(r)) : WW'(r);
      end
   endfunction

   function automatic logic [31:0] ang_align(input logic [15:0] a);
      logic [31:0] v;
      begin
         v = 32'(a) & AMask;
         return v << Sh;
      end
   endfunction

   assign wa = ang_align(r1_ff.ang_a);
   assign wb = ang_align(r1_ff.ang_b);
   assign ang_sum = (32'(r1_ff.ang_a) + 32'(r1_ff.ang_b)) & AMask;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (in_ready) v1_ff <= in_valid;
         if (adv) v2_ff <= v1_ff;
      end
      if (in_ready && in_valid) begin
         r1_ff <= in_data;
         pa_ff <= 64'(ma_abs) * 64'(GAIN_INV);
         pb_ff <= 64'(mb_abs) * 64'(GAIN_INV);
         na_ff <= in_data.mag_a[31];
         nb_ff <= in_data.mag_b[31];
      end
      if (adv && v1_ff) begin
         out_cmd    <= r1_ff.cmd;
         out_xa     <= gain_out(pa_ff, na_ff);
         out_xb     <= gain_out(pb_ff, nb_ff);
         out_za     <= wa;
         out_zb     <= wb;
         out_px     <= r1_ff.x_in;
         out_py     <= r1_ff.y_in;
         out_mag    <= r1_ff.mag_a;
         out_factor <= r1_ff.factor;
         out_ang    <= (r1_ff.cmd == CMD_ROTATE) ? 16'(ang_sum)
                                                 : 16'(32'(r1_ff.ang_a) & AMask);
      end
   end
endmodule

### hw/rtl/pvu_back.sv
// ----------------------------------------------------------------------------
// pvu_back
// pipelined cordic: two rotation lanes, a sum, a vectoring lane and output
// ----------------------------------------------------------------------------
module pvu_back #(
   parameter int CordicSteps = 16,
   parameter int AngleBits   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [2:0]         in_cmd,
   input  logic signed [pvu_pkg::WW-1:0] in_xa,
   input  logic signed [pvu_pkg::WW-1:0] in_xb,
   input  logic [31:0]        in_za,
   input  logic [31:0]        in_zb,
   input  logic signed [31:0] in_px,
   input  logic signed [31:0] in_py,
   input  logic signed [31:0] in_mag,
   input  logic signed [31:0] in_factor,
   input  logic [15:0]        in_ang,
   output logic               out_valid,
   input  logic               out_ready,
   output pvu_pkg::rsp_type   out_data
);
   import pvu_pkg::*;

   localparam int N  = CordicSteps;
   localparam int NS = 2 * N + 5;
   localparam int Sh = 32 - AngleBits;
   localparam logic [31:0] AMask = (AngleBits >= 32) ? 32'hFFFF_FFFF
                                  : ((32'd1 << AngleBits) - 32'd1);
   localparam logic signed [WW+32:0] SatHi = (WW+33)'(32'sh7FFF_FFFF);
   localparam logic signed [WW+32:0] SatLo = (WW+33)'(32'sh8000_0000);

   typedef struct packed {
      logic [2:0]           cmd;
      logic signed [WW-1:0] xa, ya, xb, yb;
      logic signed [33:0]   za, zb;
      logic signed [WW-1:0] vx, vy;
      logic [31:0]          vz;
      logic                 zero;
      logic signed [31:0]   mag, factor;
      logic [15:0]          ang;
      logic [63:0]          prod;
   } st_type;

   st_type s_ff [NS-1];
   logic   v_ff [NS];
   logic   adv;

   assign adv      = !v_ff[NS-1] || out_ready;
   assign in_ready = adv;
   assign out_valid = v_ff[NS-1];

   function automatic logic signed [33:0] pre_z(input logic [31:0] z);
      begin
         if (z >= QUARTER_TURN && z < 32'hC000_0000) return 34'(z) - 34'(HALF_TURN);
         else if (z >= 32'hC000_0000) return 34'(z) - 34'sh1_0000_0000;
         return 34'(z);
      end
   endfunction

   function automatic logic signed [31:0] sat(input logic signed [WW+32:0] v);
      begin
         if (v > SatHi) return 32'sh7FFF_FFFF;
         if (v < SatLo) return 32'sh8000_0000;
         return 32'(v);
      end
   endfunction

   function automatic logic is_sat(input logic signed [WW+32:0] v);
      return (v > SatHi) || (v < SatLo);
   endfunction

   // stage 0: quadrant fold for rotations
   always_ff @(posedge clock) begin
      st_type n;
      n        = '0;
      n.cmd    = in_cmd;
      n.mag    = in_mag;
      n.factor = in_factor;
      n.ang    = in_ang;
      n.xa     = (in_za >= QUARTER_TURN && in_za < 32'hC000_0000) ? -in_xa : in_xa;
      n.xb     = (in_zb >= QUARTER_TURN && in_zb < 32'hC000_0000) ? -in_xb : in_xb;
      n.za     = pre_z(in_za);
      n.zb     = pre_z(in_zb);
      n.vx     = WW'(in_px);
      n.vy     = WW'(in_py);
      if (reset) v_ff[0] <= 1'b0;
      else if (adv) v_ff[0] <= in_valid;
      if (adv) begin
         s_ff[0] <= n;
      end
   end

   // rotation iterations, stages 1..N
   for (genvar i = 0; i < N; i++) begin : g_rot
      localparam logic [31:0] At = atan_entry(5'(i));
      always_ff @(posedge clock) begin
         st_type n;
         n = s_ff[i];
         if (!s_ff[i].za[33]) begin
            n.xa = s_ff[i].xa - (s_ff[i].ya >>> i);
            n.ya = s_ff[i].ya + (s_ff[i].xa >>> i);
            n.za = s_ff[i].za - 34'(At);
         end else begin
            n.xa = s_ff[i].xa + (s_ff[i].ya >>> i);
            n.ya = s_ff[i].ya - (s_ff[i].xa >>> i);
            n.za = s_ff[i].za + 34'(At);
         end
         if (!s_ff[i].zb[33]) begin
            n.xb = s_ff[i].xb - (s_ff[i].yb >>> i);
            n.yb = s_ff[i].yb + (s_ff[i].xb >>> i);
            n.zb = s_ff[i].zb - 34'(At);
         end else begin
            n.xb = s_ff[i].xb + (s_ff[i].yb >>> i);
            n.yb = s_ff[i].yb - (s_ff[i].xb >>> i);
            n.zb = s_ff[i].zb + 34'(At);
         end
         if (reset) v_ff[i+1] <= 1'b0;
         else if (adv) v_ff[i+1] <= v_ff[i];
         if (adv) begin
            s_ff[i+1] <= n;
         end
      end
   end

   // stage N+1: pick vectoring input, fold to right half plane, form scale product
   logic signed [WW-1:0] sx, sy;
   always_comb begin
      if (s_ff[N].cmd == CMD_ADD) begin
         sx = s_ff[N].xa + s_ff[N].xb;
         sy = s_ff[N].ya + s_ff[N].yb;
      end else begin
         sx = s_ff[N].vx;
         sy = s_ff[N].vy;
      end
   end

   always_ff @(posedge clock) begin
      st_type n;
      n      = s_ff[N];
      n.zero = (sx == '0) && (sy == '0);
      n.vx   = sx[WW-1] ? -sx : sx;
      n.vy   = sx[WW-1] ? -sy : sy;
      n.vz   = sx[WW-1] ? HALF_TURN : 32'h0;
      n.prod = 64'($signed(s_ff[N].mag) * $signed(s_ff[N].factor));
      if (reset) v_ff[N+1] <= 1'b0;
      else if (adv) v_ff[N+1] <= v_ff[N];
      if (adv) begin
         s_ff[N+1] <= n;
      end
   end

   // vectoring iterations
   for (genvar i = 0; i < N; i++) begin : g_vec
      localparam logic [31:0] At = atan_entry(5'(i));
      always_ff @(posedge clock) begin
         st_type n;
         n = s_ff[N+1+i];
         if (!s_ff[N+1+i].vy[WW-1]) begin
            n.vx = s_ff[N+1+i].vx + (s_ff[N+1+i].vy >>> i);
            n.vy = s_ff[N+1+i].vy - (s_ff[N+1+i].vx >>> i);
            n.vz = s_ff[N+1+i].vz + At;
         end else begin
            n.vx = s_ff[N+1+i].vx - (s_ff[N+1+i].vy >>> i);
            n.vy = s_ff[N+1+i].vy + (s_ff[N+1+i].vx >>> i);
            n.vz = s_ff[N+1+i].vz - At;
         end
         if (reset) v_ff[N+2+i] <= 1'b0;
         else if (adv) v_ff[N+2+i] <= v_ff[N+1+i];
         if (adv) begin
            s_ff[N+2+i] <= n;
         end
      end
   end

   // gain multiply on vectoring magnitude, split into two 16-bit halves
   logic [63:0] gh_ff, gl_ff;
   always_ff @(posedge clock) begin
      if (reset) v_ff[2*N+2] <= 1'b0;
      else if (adv) v_ff[2*N+2] <= v_ff[2*N+1];
      if (adv) begin
         s_ff[2*N+2] <= s_ff[2*N+1];
         gh_ff <= 64'(s_ff[2*N+1].vx[WW-2:0]) * 64'(GAIN_INV[31:16]);
         gl_ff <= 64'(s_ff[2*N+1].vx[WW-2:0]) * 64'(GAIN_INV[15:0]);
      end
   end

   logic [63:0] gm_ff;
   always_ff @(posedge clock) begin
      if (reset) v_ff[2*N+3] <= 1'b0;
      else if (adv) v_ff[2*N+3] <= v_ff[2*N+2];
      if (adv) begin
         s_ff[2*N+3] <= s_ff[2*N+2];
         gm_ff <= (gh_ff + ((gl_ff + 64'h8000_0000) >> 16)) >> 16;
      end
   end

   // final result
   logic signed [WW+32:0] sc_r;
   logic [32:0]           zr;
   rsp_type               res;
   st_type                f;
   always_comb begin
      f    = s_ff[2*N+3];
      sc_r = (WW+33)'($signed(f.prod) + 64'sd32768) >>> 16;
      zr   = (33'(f.vz) + ((Sh > 0) ? (33'd1 << (Sh > 0 ? Sh-1 : 0)) : 33'd0)) >> Sh;
      res  = '0;
      case (f.cmd) inside
         CMD_TO_POLAR, CMD_ADD: begin
            if (!f.zero) begin
               res.mag_out   = sat((WW+33)'(gm_ff));
               res.saturated = is_sat((WW+33)'(gm_ff));
               res.ang_out   = 16'(32'(zr) & AMask);
            end
         end
         CMD_TO_POINT: begin
            res.x_out     = sat((WW+33)'(f.xa));
            res.y_out     = sat((WW+33)'(f.ya));
            res.saturated = is_sat((WW+33)'(f.xa)) || is_sat((WW+33)'(f.ya));
         end
         CMD_SCALE: begin
            res.mag_out   = sat(sc_r);
            res.saturated = is_sat(sc_r);
            res.ang_out   = f.ang;
         end
         CMD_ROTATE: begin
            res.mag_out = f.mag;
            res.ang_out = f.ang;
         end
         default: res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[NS-1] <= 1'b0;
      else if (adv) v_ff[NS-1] <= v_ff[NS-2];
      if (adv) begin
         out_data <= res;
      end
   end
endmodule

### hw/rtl/polar_vector_unit.sv
// a request passes the front gain and output registers, the decoupling queue, the cordic
// pipeline and the response queue before its response can be popped
// throughput: one request per cycle unless stalled, set by the unrolled cordic stages
// a full response queue stalls the cordic pipeline; the front keeps filling its own queue
// reset: synchronous, active high; clears all valid bits and queue pointers, no data cleared
// ----------------------------------------------------------------------------
// polar_vector_unit
// cordic based polar/rectangular vector unit with queue style ports
// ----------------------------------------------------------------------------
module polar_vector_unit #(
   parameter int CORDIC_STEPS = pvu_pkg::CordicStepsDefault,
   parameter int ANGLE_BITS   = pvu_pkg::AngleBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pvu_pkg::req_type req_data,
   output logic             full,
   input  logic             pop,
   output pvu_pkg::rsp_type rsp_data,
   output logic             empty
);
   import pvu_pkg::*;

   localparam int QW = 3 + 2*WW + 64 + 4*32 + 16;

   // decoupling queue handshake between front and back
   logic q_ready, q_full, q_empty, b_ready;

   // front stage: gain scaling and angle alignment
   logic f_valid, f_ready;
   logic [2:0] f_cmd;
   logic signed [WW-1:0] f_xa, f_xb;
   logic [31:0] f_za, f_zb;
   logic signed [31:0] f_px, f_py, f_mag, f_factor;
   logic [15:0] f_ang;

   pvu_front #(.AngleBits(ANGLE_BITS)) u_front (
      .clock, .reset,
      .in_data(req_data), .in_valid(push), .in_ready(f_ready),
      .out_valid(f_valid), .out_ready(q_ready),
      .out_cmd(f_cmd), .out_xa(f_xa), .out_xb(f_xb), .out_za(f_za), .out_zb(f_zb),
      .out_px(f_px), .out_py(f_py), .out_mag(f_mag), .out_factor(f_factor),
      .out_ang(f_ang)
   );
   assign full = !f_ready;

   // decoupling queue between front and back
   logic [QW-1:0] q_in, q_out;
   assign q_in    = {f_cmd, f_xa, f_xb, f_za, f_zb, f_px, f_py, f_mag, f_factor, f_ang};
   assign q_ready = !q_full;

   pvu_fifo #(.Width(QW), .Depth(4)) u_queue (
      .clock, .reset,
      .push(f_valid), .push_data(q_in), .full(q_full),
      .pop(b_ready), .pop_data(q_out), .empty(q_empty)
   );

   // back stage: cordic pipeline
   logic b_valid, r_full;
   rsp_type b_data;
   pvu_back #(.CordicSteps(CORDIC_STEPS), .AngleBits(ANGLE_BITS)) u_back (
      .clock, .reset,
      .in_valid(!q_empty), .in_ready(b_ready),
      .in_cmd(q_out[QW-1 -: 3]),
      .in_xa(q_out[QW-4 -: WW]),
      .in_xb(q_out[QW-4-WW -: WW]),
      .in_za(q_out[QW-4-2*WW -: 32]),
      .in_zb(q_out[QW-36-2*WW -: 32]),
      .in_px(q_out[16+127 -: 32]),
      .in_py(q_out[16+95 -: 32]),
      .in_mag(q_out[16+63 -: 32]),
      .in_factor(q_out[16+31 -: 32]),
      .in_ang(q_out[15:0]),
      .out_valid(b_valid), .out_ready(!r_full),
      .out_data(b_data)
   );

   // response queue
   pvu_fifo #(.Width($bits(rsp_type)), .Depth(2)) u_rsp (
      .clock, .reset,
      .push(b_valid), .push_data(b_data), .full(r_full),
      .pop(pop), .pop_data(rsp_data), .empty(empty)
   );

`ifndef SYNTH
   // a result on a stalled response side must not be lost
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      b_valid && r_full |=> b_valid) else $error("back result dropped");
   // queue never claims to be both full and empty
   a_q_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty)) else $error("queue state broken");
   a_rsp_sane: assert property (@(posedge clock) disable iff (reset)
      !(r_full && empty)) else $error("response queue broken");
`endif
endmodule

### bench/pvu_checker.sv
// ----------------------------------------------------------------------------
// pvu_checker
// watches both queue ports of the polar vector unit, works out the expected
// response of every request transfer and compares each response transfer
// ----------------------------------------------------------------------------
module pvu_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  pvu_pkg::req_type req_data,
   input  logic             pop,
   input  logic             empty,
   input  pvu_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import pvu_pkg::*;

   localparam int Steps = CordicStepsDefault;
   localparam int AngBits = AngleBitsDefault;

   rsp_type expected_rsp_q[$];

   function automatic logic [31:0] arctan_step(input int i);
      logic [31:0] t [30] = '{
         32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
         32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
         32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
         32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
         32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
         32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
      return t[i];
   endfunction

   // unsigned magnitude times the inverse cordic gain, rounded half up
   function automatic longint unsigned strip_gain(input longint unsigned m);
      longint unsigned hi, lo;
      hi = GAIN_INV >> 16;
      lo = GAIN_INV & 32'hFFFF;
      return (m * hi + ((m * lo + 64'h8000_0000) >> 16)) >> 16;
   endfunction

   function automatic longint clip32(input longint v, inout bit clipped);
      if (v > 64'sd2147483647) begin
         clipped = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clipped = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic logic [31:0] widen_angle(input logic [15:0] a);
      return (32'(a) & 32'((64'd1 << AngBits) - 1)) << (32 - AngBits);
   endfunction

   // rotation mode: magnitude and 32-bit turn angle to a point
   function automatic void polar_to_point(input longint mag, input logic [31:0] z,
                                          output longint px, output longint py);
      longint x, y, zz, nx, ny;
      x = (mag < 0) ? -longint'(strip_gain(-mag)) : longint'(strip_gain(mag));
      y = 0;
      zz = longint'({32'h0, z});
      if (z >= QUARTER_TURN && z < 32'hC000_0000) begin
         x = -x;
         zz -= 64'sh8000_0000;
      end else if (z >= 32'hC000_0000) begin
         zz -= 64'sh1_0000_0000;
      end
      for (int i = 0; i < Steps && i < TableLen; i++) begin
         if (zz >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); zz -= arctan_step(i);
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); zz += arctan_step(i);
         end
         x = nx; y = ny;
      end
      px = x; py = y;
   endfunction

   // vectoring mode with the half turn fold for negative x
   function automatic void point_to_polar(input longint x, input longint y,
                                          output longint unsigned mag,
                                          output logic [31:0] z);
      longint nx, ny;
      z = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         return;
      end
      if (x < 0) begin
         x = -x; y = -y; z = HALF_TURN;
      end
      for (int i = 0; i < Steps && i < TableLen; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_step(i);
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_step(i);
         end
         x = nx; y = ny;
      end
      mag = strip_gain(x);
   endfunction

   function automatic logic [15:0] narrow_angle(input logic [31:0] z);
      longint unsigned half;
      half = (AngBits < 32) ? (64'd1 << (31 - AngBits)) : 0;
      return 16'(((64'(z) + half) >> (32 - AngBits)) & ((64'd1 << AngBits) - 1));
   endfunction

   function automatic rsp_type vector_result(input req_type r);
      rsp_type o;
      bit clipped;
      longint x, y, xa, ya, xb, yb;
      longint unsigned m;
      logic [31:0] z;
      o = '0;
      clipped = 0;
      case (r.cmd) inside
         CMD_TO_POLAR, CMD_ADD: begin
            if (r.cmd == CMD_TO_POLAR) begin
               x = r.x_in; y = r.y_in;
            end else begin
               polar_to_point(r.mag_a, widen_angle(r.ang_a), xa, ya);
               polar_to_point(r.mag_b, widen_angle(r.ang_b), xb, yb);
               x = xa + xb; y = ya + yb;
            end
            point_to_polar(x, y, m, z);
            o.mag_out = 32'(clip32(longint'(m), clipped));
            o.ang_out = narrow_angle(z);
         end
         CMD_TO_POINT: begin
            polar_to_point(r.mag_a, widen_angle(r.ang_a), x, y);
            o.x_out = 32'(clip32(x, clipped));
            o.y_out = 32'(clip32(y, clipped));
         end
         CMD_SCALE: begin
            x = longint'(r.mag_a) * longint'(r.factor);
            o.mag_out = 32'(clip32((x + 32768) >>> 16, clipped));
            o.ang_out = r.ang_a;
         end
         CMD_ROTATE: begin
            o.mag_out = r.mag_a;
            o.ang_out = r.ang_a + r.ang_b;
         end
         default: o = '0;
      endcase
      o.saturated = clipped;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mismatch_count = 0;
         expected_rsp_q.delete();
      end else begin
         if (push && !full)
            expected_rsp_q.push_back(vector_result(req_data));
         if (pop && !empty) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected response", 32'(rsp_data.mag_out), 32'd0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.x_out !== want.x_out)
                  report_mismatch("x_out", rsp_data.x_out, want.x_out);
               if (rsp_data.y_out !== want.y_out)
                  report_mismatch("y_out", rsp_data.y_out, want.y_out);
               if (rsp_data.mag_out !== want.mag_out)
                  report_mismatch("mag_out", rsp_data.mag_out, want.mag_out);
               if (rsp_data.ang_out !== want.ang_out)
                  report_mismatch("ang_out", 32'(rsp_data.ang_out), 32'(want.ang_out));
               if (rsp_data.saturated !== want.saturated)
                  report_mismatch("saturated", 32'(rsp_data.saturated),
                                  32'(want.saturated));
            end
         end
      end
      pending_count = expected_rsp_q.size();
   end
endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives directed and random vector commands into the polar vector unit under
// changing idle and stall patterns and gives the verdict from the checker
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pvu_pkg::*;

   localparam int RandomItems = 930;
   localparam int IdleLimit = 20000;
   localparam int Latency = 2 * CordicStepsDefault + 9;

   logic    clock;
   logic    reset;
   logic    push;
   req_type req_data;
   logic    full;
   logic    pop;
   rsp_type rsp_data;
   logic    empty;
   int      mismatch_count;
   int      pending_count;

   // percentage of cycles each side holds back, changed per phase
   int      send_idle_pct;
   int      recv_stall_pct;
   int      quiet_cycles;

   polar_vector_unit dut (
      .clock(clock), .reset(reset),
      .push(push), .req_data(req_data), .full(full),
      .pop(pop), .rsp_data(rsp_data), .empty(empty)
   );

   pvu_checker checker_i (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_data(req_data),
      .pop(pop), .empty(empty), .rsp_data(rsp_data),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver side: pop decided afresh at every falling edge
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: ends the run if nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // place one request and hold it until the transfer happens; push stays
   // high on return so requests can follow back to back
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 0;
         @(negedge clock);
      end
      push <= 1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] edgy_word();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'($signed($urandom_range(8'hFF)) - 128);
         4: return 32'($urandom_range(32'h000F_FFFF)) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      r.mag_a = edgy_word();
      r.mag_b = edgy_word();
      r.x_in = edgy_word();
      r.y_in = edgy_word();
      r.factor = edgy_word();
      r.ang_a = 16'($urandom);
      r.ang_b = 16'($urandom);
      return r;
   endfunction

   function automatic req_type make_req(input logic [2:0] c, input logic [31:0] ma,
                                        input logic [15:0] aa, input logic [31:0] mb,
                                        input logic [15:0] ab, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] f);
      req_type r;
      r.cmd = c; r.mag_a = ma; r.ang_a = aa; r.mag_b = mb; r.ang_b = ab;
      r.x_in = x; r.y_in = y; r.factor = f;
      return r;
   endfunction

   initial begin
      push = 0;
      req_data = '0;
      reset = 1;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: zero point, negative x fold, extremes, negative magnitude, add, scale, rotate, unused codes
      send_request(make_req(CMD_TO_POLAR, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_TO_POLAR, 0, 0, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0));
      send_request(make_req(CMD_TO_POLAR, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 0));
      send_request(make_req(CMD_TO_POLAR, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
      send_request(make_req(CMD_TO_POLAR, 0, 0, 0, 0, 0, 32'hFFFF_0000, 0));
      send_request(make_req(CMD_TO_POINT, 32'h0001_0000, 16'h0000, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_TO_POINT, 32'h7FFF_FFFF, 16'h4000, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_TO_POINT, 32'h8000_0000, 16'hFFFF, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_TO_POINT, 32'hFFFE_0000, 16'hC000, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_ADD, 32'h0001_0000, 16'h0000, 32'h0001_0000, 16'h8000,
                            0, 0, 0));
      send_request(make_req(CMD_ADD, 32'h7FFF_FFFF, 16'h2000, 32'h7FFF_FFFF, 16'h2000,
                            0, 0, 0));
      send_request(make_req(CMD_ADD, 32'h8000_0000, 16'hFFFF, 32'h8000_0000, 16'h0001,
                            0, 0, 0));
      send_request(make_req(CMD_SCALE, 32'h7FFF_FFFF, 16'hFFFF, 0, 0, 0, 0, 32'h7FFF_FFFF));
      send_request(make_req(CMD_SCALE, 32'h8000_0000, 16'h1234, 0, 0, 0, 0, 32'h8000_0000));
      send_request(make_req(CMD_SCALE, 32'hFFFF_8000, 16'h0000, 0, 0, 0, 0, 32'h0000_0001));
      send_request(make_req(CMD_ROTATE, 32'hFFFF_FFFF, 16'hFFFF, 0, 16'h0001, 0, 0, 0));
      send_request(make_req(CMD_ROTATE, 32'h8000_0000, 16'h8000, 0, 16'h8000, 0, 0, 0));
      send_request(make_req(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_req(3'd6, 1, 1, 1, 1, 1, 1, 1));
      send_request(make_req(3'd7, 0, 0, 0, 0, 0, 0, 0));
      push <= 0;

      // hold off until the pipeline has drained completely
      while (pending_count != 0) @(negedge clock);

      // random phases: none, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 20 : 54) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 20 : 54) : 0;
         for (int n = 0; n < RandomItems / 4; n++)
            send_request(random_request());
      end
      push <= 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;

      while (pending_count != 0) @(negedge clock);
      repeat (Latency + 10) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
